@@ hdl/fspr_pkg.sv @@
// Shared types and codes of the frame slot pool.
`timescale 1ns / 1ps
`default_nettype none
package fspr_pkg;

	typedef enum logic [1:0] {
		MODE_PUT        = 2'd0,
		MODE_GET_AFTER  = 2'd1,
		MODE_GET_LATEST = 2'd2,
		MODE_RELEASE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_TOO_LARGE = 2'd1,
		STAT_NO_FREE   = 2'd2,
		STAT_NO_MATCH  = 2'd3
	} status_t;

	localparam logic [7:0]  REF_MAX         = 8'hFF;
	localparam logic [23:0] MAX_FRAME_RESET = 24'd61440;

	// descriptor held by one age position
	typedef struct packed {
		logic [31:0] stamp;
		logic [3:0]  fmt;
		logic [23:0] len;
		logic [7:0]  refc;
	} desc_t;

	// scan control broadcast to every cell
	typedef struct packed {
		logic        tok_start;
		logic        tok_shift;
		logic        tok_down;
		mode_t       mode;
		logic [31:0] stamp;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ hdl/fspr_if.sv @@
// Request and response channel interfaces of the frame slot pool.
`timescale 1ns / 1ps
`default_nettype none
interface fspr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] timestamp;
	logic [3:0]  format;
	logic [23:0] frame_size;
	logic [2:0]  slot;

	modport source (output valid, mode, timestamp, format, frame_size, slot, input ready);
	modport sink   (input valid, mode, timestamp, format, frame_size, slot, output ready);
endinterface

interface fspr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  result_slot;
	logic [31:0] frame_stamp;
	logic [3:0]  frame_format;
	logic [23:0] frame_bytes;

	modport source (output valid, status, result_slot, frame_stamp, frame_format, frame_bytes,
		input ready);
	modport sink   (input valid, status, result_slot, frame_stamp, frame_format, frame_bytes,
		output ready);
endinterface
`default_nettype wire

@@ hdl/fspr_cell.sv @@
// One age position of the slot pool: slot id, descriptor and scan token.
`timescale 1ns / 1ps
`default_nettype none
module fspr_cell #(
	parameter int NUM_SLOTS = 5,
	parameter int IDX       = 0,
	parameter int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fspr_pkg::cell_ctl_t ctl,
	input  wire logic [SW-1:0]       rel_id,
	input  wire logic                tok_lo,
	input  wire logic                tok_hi,
	input  wire logic                inc,
	input  wire logic                dec,
	input  wire logic                load,
	input  wire logic [SW-1:0]       above_id,
	input  wire fspr_pkg::desc_t     above_desc,
	output logic                     tok,
	output logic                     hit,
	output logic [SW-1:0]            id,
	output fspr_pkg::desc_t          desc
);
	import fspr_pkg::*;

	logic [SW-1:0] id_q;
	desc_t         desc_q;
	logic          tok_q;

	assign tok  = tok_q;
	assign id   = id_q;
	assign desc = desc_q;

	always_comb begin
		unique case (ctl.mode)
			MODE_PUT:        hit = (desc_q.refc == 8'd0);
			MODE_GET_AFTER:  hit = (desc_q.len != 24'd0) && (desc_q.stamp >= ctl.stamp);
			MODE_GET_LATEST: hit = (desc_q.len != 24'd0);
			MODE_RELEASE:    hit = (id_q == rel_id);
			default:         hit = 1'b0;
		endcase
	end

	// token walks one position a cycle while tok_shift is set, upward (older to newer) or downward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.tok_start) begin
			tok_q <= ctl.tok_down ? (IDX == NUM_SLOTS - 1) : (IDX == 0);
		end else if (ctl.tok_shift) begin
			tok_q <= ctl.tok_down ? tok_hi : tok_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q   <= SW'(IDX);
			desc_q <= '0;
		end else if (load) begin
			id_q   <= above_id;
			desc_q <= above_desc;
		end else if (inc) begin
			if (desc_q.refc != REF_MAX)
				desc_q.refc <= desc_q.refc + 8'd1;
		end else if (dec) begin
			if (desc_q.refc != 8'd0)
				desc_q.refc <= desc_q.refc - 8'd1;
		end
	end

endmodule
`default_nettype wire

@@ hdl/frame_slot_pool_refcount_top.sv @@
// Top level of the reference-counted frame slot pool.
`timescale 1ns / 1ps
`default_nettype none
// Frame slot pool with reference counts and oldest-first reuse. The pool is a
// row of NUM_SLOTS cells in age order, oldest at cell 0; each cell holds a slot
// index and that slot's descriptor (stamp, format, byte length, ref count).
// One request transaction is taken at a time. After acceptance a one-bit scan
// token walks the row, one cell per cycle: from the oldest cell for put, get
// at-or-after and release, from the newest for get-latest. The first cell that
// matches under the token is acted on in that same cycle: a get bumps its count
// (saturating at 255), a release drops a count above zero, a put moves every
// newer cell down one place and writes the new descriptor into the newest cell,
// which takes the freed slot index. An item passes from acceptance through the
// scan, which stops at the first match or at the end of the row, to the response
// register; oversize puts and out-of-range releases skip the scan. The response
// sits in an output register, so the next request is taken while an earlier
// response still awaits its consumer. max_frame_bytes is written through
// cfg_we / cfg_wdata; write it only while idle, which the block itself does not
// enforce.
module frame_slot_pool_refcount_top #(
	parameter int NUM_SLOTS = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	fspr_req_if.sink         req,
	fspr_rsp_if.source       rsp,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata
);
	import fspr_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	// wide enough for a slot field, an internal id, and NUM_SLOTS itself
	localparam int RW = ((SW > 3) ? SW : 3) + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t        state_q;
	logic [23:0]   max_q;

	// latched request
	mode_t         mode_q;
	logic [31:0]   stamp_q;
	logic [3:0]    fmt_q;
	logic [23:0]   size_q;
	logic [SW-1:0] rel_q;
	logic [SW-1:0] cnt_q;

	// pending response
	status_t       res_status_q;
	logic [2:0]    res_slot_q;
	logic [31:0]   res_stamp_q;
	logic [3:0]    res_fmt_q;
	logic [23:0]   res_len_q;

	// output register
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [2:0]    out_slot_q;
	logic [31:0]   out_stamp_q;
	logic [3:0]    out_fmt_q;
	logic [23:0]   out_len_q;

	// cell row
	cell_ctl_t      ctl;
	logic [NUM_SLOTS-1:0] tok_vec, hit_flag, hit_vec, ge_mask;
	logic [NUM_SLOTS-1:0] inc_vec, dec_vec, load_vec;
	logic [SW-1:0]  cid   [NUM_SLOTS];
	desc_t          cdesc [NUM_SLOTS];
	logic [SW-1:0]  above_id   [NUM_SLOTS];
	desc_t          above_desc [NUM_SLOTS];

	logic          accept, any_hit, scan_end, out_load;
	logic [RW-1:0] rel_ext, sel_ext;
	logic [SW-1:0] sel_id;
	desc_t         sel_desc, new_desc;
	mode_t         req_mode;

	assign req_mode = mode_t'(req.mode);
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign rel_ext   = RW'(req.slot);

	// scan control shared by all cells
	always_comb begin
		ctl.tok_start = accept;
		ctl.tok_shift = (state_q == ST_SCAN) && !any_hit;
		ctl.tok_down  = (state_q == ST_IDLE) ? (req_mode == MODE_GET_LATEST)
		                                     : (mode_q == MODE_GET_LATEST);
		ctl.mode      = mode_q;
		ctl.stamp     = stamp_q;
	end

	assign hit_vec = (state_q == ST_SCAN) ? (tok_vec & hit_flag) : '0;
	assign any_hit = |hit_vec;
	assign scan_end = (cnt_q == SW'(NUM_SLOTS - 1));
	// cells at or above the hit position: the token is one-hot
	assign ge_mask = ~(hit_vec - NUM_SLOTS'(1));

	// one-hot select of the hit cell
	always_comb begin
		sel_id   = '0;
		sel_desc = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (hit_vec[i]) begin
				sel_id   = sel_id | cid[i];
				sel_desc = sel_desc | cdesc[i];
			end
		end
	end
	assign sel_ext = RW'(sel_id);

	always_comb begin
		new_desc       = '0;
		new_desc.stamp = stamp_q;
		new_desc.fmt   = fmt_q;
		new_desc.len   = size_q;
	end

	assign inc_vec  = (mode_q == MODE_GET_AFTER || mode_q == MODE_GET_LATEST) ? hit_vec : '0;
	assign dec_vec  = (mode_q == MODE_RELEASE) ? hit_vec : '0;
	assign load_vec = (mode_q == MODE_PUT) ? ge_mask : '0;

	genvar g;
	generate
		for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
			if (g == NUM_SLOTS - 1) begin : g_top
				assign above_id[g]   = sel_id;
				assign above_desc[g] = new_desc;
			end else begin : g_mid
				assign above_id[g]   = cid[g+1];
				assign above_desc[g] = cdesc[g+1];
			end

			fspr_cell #(
				.NUM_SLOTS (NUM_SLOTS),
				.IDX       (g)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.rel_id     (rel_q),
				.tok_lo     ((g > 0) ? tok_vec[(g > 0) ? g - 1 : 0] : 1'b0),
				.tok_hi     ((g < NUM_SLOTS - 1) ? tok_vec[(g < NUM_SLOTS - 1) ? g + 1 : g] : 1'b0),
				.inc        (inc_vec[g]),
				.dec        (dec_vec[g]),
				.load       (load_vec[g]),
				.above_id   (above_id[g]),
				.above_desc (above_desc[g]),
				.tok        (tok_vec[g]),
				.hit        (hit_flag[g]),
				.id         (cid[g]),
				.desc       (cdesc[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_FRAME_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= req_mode;
			stamp_q <= req.timestamp;
			fmt_q   <= req.format;
			size_q  <= req.frame_size;
			rel_q   <= rel_ext[SW-1:0];
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			res_status_q <= STAT_OK;
			res_slot_q   <= '0;
			res_stamp_q  <= '0;
			res_fmt_q    <= '0;
			res_len_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q       <= '0;
						res_slot_q  <= '0;
						res_stamp_q <= '0;
						res_fmt_q   <= '0;
						res_len_q   <= '0;
						priority if (req_mode == MODE_PUT && req.frame_size > max_q) begin
							res_status_q <= STAT_TOO_LARGE;
							state_q      <= ST_DONE;
						end else if (req_mode == MODE_RELEASE &&
							rel_ext >= RW'(NUM_SLOTS)) begin
							res_status_q <= STAT_NO_MATCH;
							state_q      <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					priority if (any_hit) begin
						res_status_q <= STAT_OK;
						res_slot_q   <= sel_ext[2:0];
						if (mode_q == MODE_PUT) begin
							res_stamp_q <= stamp_q;
							res_fmt_q   <= fmt_q;
							res_len_q   <= size_q;
						end else begin
							res_stamp_q <= sel_desc.stamp;
							res_fmt_q   <= sel_desc.fmt;
							res_len_q   <= sel_desc.len;
						end
						state_q <= ST_DONE;
					end else if (scan_end) begin
						res_status_q <= (mode_q == MODE_PUT) ? STAT_NO_FREE : STAT_NO_MATCH;
						state_q      <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + SW'(1);
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_stamp_q  <= res_stamp_q;
			out_fmt_q    <= res_fmt_q;
			out_len_q    <= res_len_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.result_slot  = out_slot_q;
	assign rsp.frame_stamp  = out_stamp_q;
	assign rsp.frame_format = out_fmt_q;
	assign rsp.frame_bytes  = out_len_q;

	// exactly one cell carries the token while scanning
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> $onehot(tok_vec))
		else $error("scan token not one-hot");

	// an accepted transaction always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN || state_q == ST_DONE))
		else $error("request accepted but sequencer stayed idle");

	// a successful put places the reused slot at the newest position
	a_put_newest: assert property (@(posedge clk) disable iff (!arst_n)
		(any_hit && mode_q == MODE_PUT) |=> cid[NUM_SLOTS-1] == $past(sel_id))
		else $error("put did not move slot to newest position");

	// the response register is never overwritten while still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !out_load)
		else $error("pending response overwritten");

endmodule
`default_nettype wire
